[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the drive power state machine.
// Pulled in by `include; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, masked while reset is asserted (reset is active low).
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

[rtl/core/dsm_pkg.sv]
// Shared types and constants for the drive power state machine.
// No dependencies; imported by every module of the block.
package dsm_pkg;

    // controlword bits and command patterns
    localparam logic [15:0] CW_FAULT_RESET = 16'h0080;
    localparam logic [15:0] CW_MASK_CMD    = 16'h0087;
    localparam logic [15:0] CW_SHUTDOWN    = 16'h0006;
    localparam logic [15:0] CW_SWITCH_ON   = 16'h0007;
    localparam logic [15:0] CW_MASK_OP     = 16'h000F;
    localparam logic [15:0] CW_ENABLE_OP   = 16'h000F;
    localparam logic [15:0] CW_DISABLE_OP  = 16'h0007;
    localparam logic [15:0] CW_EN_VOLTAGE  = 16'h0002;
    localparam logic [15:0] CW_QUICK_STOP  = 16'h0004;
    localparam logic [15:0] CW_CALIBRATE   = 16'h0100;

    // statusword
    localparam logic [15:0] SW_VOLTAGE     = 16'h0010;
    localparam logic [15:0] SW_RESET_VALUE = 16'h0040;

    // item commands
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_FAULT  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] control_word;
        logic        guard_ok;
    } t_item;

    typedef struct packed {
        logic [3:0]  drive_state;
        logic [15:0] status_word;
        logic        pwm_on;
        logic        state_changed;
    } t_result;

    // Status pattern per state code, voltage-enabled bit already set.
    function automatic logic [15:0] status_of(input logic [3:0] code);
        logic [15:0] pat;
        case (code)
            4'd0:    pat = 16'h0000;
            4'd1:    pat = 16'h0040;
            4'd2:    pat = 16'h0021;
            4'd3:    pat = 16'h0023;
            4'd4:    pat = 16'h0027;
            4'd5:    pat = 16'h0007;
            4'd6:    pat = 16'h000F;
            4'd7:    pat = 16'h0008;
            4'd8:    pat = 16'h0100;
            default: pat = 16'h0000;
        endcase
        return pat | SW_VOLTAGE;
    endfunction

endpackage

[rtl/core/drive_power_state_machine.sv]
// Top level of the drive power state machine (DS402 style, plus calibrating).
// Depends on dsm_pkg, dsm_in_stage and dsm_core.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  request | in        | i_valid / o_stall      | i_cmd, i_control_word, i_guard_ok
//  result  | out       | o_valid / i_stall      | o_drive_state, o_status_word, o_pwm_on,
//          |           |                        | o_state_changed
//
// An accepted request passes the input register, then the result register. One request
// is accepted every cycle while o_stall is low. The input register feeds a single pass of
// transition logic that updates the drive state and the result register together.
// Reset (i_rst_n low, synchronous) puts the drive in not-ready with statusword 0x0040.
// A stall on the result side holds the result register; the input register still
// takes one more request, and o_stall rises only while both are full.
module drive_power_state_machine import dsm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [15:0] i_control_word,
    input  logic        i_guard_ok,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_drive_state,
    output logic [15:0] o_status_word,
    output logic        o_pwm_on,
    output logic        o_state_changed
);

    t_item   w_in_item;
    t_item   w_held_item;
    logic    w_held_valid;
    logic    w_advance;
    logic    w_commit;
    t_result w_result;
    logic    r_out_valid;

    assign w_in_item.cmd          = i_cmd;
    assign w_in_item.control_word = i_control_word;
    assign w_in_item.guard_ok     = i_guard_ok;

    // result register is free when empty or being taken this cycle
    assign w_advance = !r_out_valid || !i_stall;
    // the held request updates the drive state as it moves to the result register
    assign w_commit  = w_advance && w_held_valid;

    dsm_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_stall   (o_stall),
        .o_valid   (w_held_valid),
        .o_item    (w_held_item)
    );

    dsm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_held_item),
        .i_commit (w_commit),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_held_valid;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_drive_state   = w_result.drive_state;
    assign o_status_word   = w_result.status_word;
    assign o_pwm_on        = w_result.pwm_on;
    assign o_state_changed = w_result.state_changed;

endmodule

[rtl/core/dsm_in_stage.sv]
// Input register stage of the drive power state machine.
// Depends on dsm_pkg (t_item).
module dsm_in_stage import dsm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_stall,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    // take a new request when empty or when the held one moves on this cycle
    assign w_load  = !r_valid || i_advance;
    assign o_stall = !w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/core/dsm_core.sv]
// Drive state, transition logic and result register.
// Depends on dsm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dsm_core import dsm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  logic    i_commit,
    output t_result o_result
);

    typedef enum logic [3:0] {
        ST_NOTREADY = 4'd0,
        ST_DISABLED = 4'd1,
        ST_READY    = 4'd2,
        ST_SWON     = 4'd3,
        ST_ENABLED  = 4'd4,
        ST_QSTOP    = 4'd5,
        ST_FREACT   = 4'd6,
        ST_FAULT    = 4'd7,
        ST_CALIB    = 4'd8
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [15:0] r_last, n_last;
    logic [15:0] r_status, n_status;
    logic        r_pwm, n_pwm;
    t_result     r_result;

    t_mode       w_mode1;
    t_mode       w_target;
    logic        w_pwm1;

    // first matching controlword transition; returns the state itself if none
    function automatic t_mode cw_target(input t_mode m, input logic [15:0] cw,
                                        input logic [15:0] last);
        t_mode t;
        t = m;
        case (m)
            ST_NOTREADY: t = ST_DISABLED;
            ST_DISABLED: begin
                if ((cw & CW_MASK_CMD) == CW_SHUTDOWN) t = ST_READY;
            end
            ST_READY: begin
                if ((cw & CW_MASK_CMD) == CW_SWITCH_ON)  t = ST_SWON;
                else if ((cw & CW_EN_VOLTAGE) == '0)     t = ST_DISABLED;
                else if ((cw & CW_CALIBRATE) != '0)      t = ST_CALIB;
            end
            ST_SWON: begin
                if ((cw & CW_MASK_CMD) == CW_SHUTDOWN)   t = ST_READY;
                else if ((cw & CW_EN_VOLTAGE) == '0)     t = ST_DISABLED;
                else if ((cw & CW_MASK_OP) == CW_ENABLE_OP) t = ST_ENABLED;
            end
            ST_ENABLED: begin
                if ((cw & CW_MASK_CMD) == CW_SHUTDOWN)   t = ST_READY;
                else if ((cw & CW_EN_VOLTAGE) == '0)     t = ST_DISABLED;
                else if ((cw & CW_MASK_OP) == CW_DISABLE_OP) t = ST_SWON;
                else if ((cw & CW_QUICK_STOP) == '0)     t = ST_QSTOP;
            end
            ST_QSTOP: begin
                if ((cw & CW_EN_VOLTAGE) == '0)          t = ST_DISABLED;
                else if ((cw & CW_MASK_OP) == CW_ENABLE_OP) t = ST_ENABLED;
            end
            ST_CALIB: begin
                if ((cw & CW_EN_VOLTAGE) == '0)          t = ST_DISABLED;
            end
            ST_FREACT: t = ST_FAULT;
            ST_FAULT: begin
                // fault reset on a rising edge of the reset bit
                if ((cw & CW_FAULT_RESET) != '0 && (last & CW_FAULT_RESET) == '0)
                    t = ST_DISABLED;
            end
            default: t = m;
        endcase
        return t;
    endfunction

    function automatic logic pwm_after(input t_mode tgt, input logic cur);
        logic p;
        case (tgt)
            ST_ENABLED:  p = 1'b1;
            ST_DISABLED: p = 1'b0;
            ST_FAULT:    p = 1'b0;
            default:     p = cur;
        endcase
        return p;
    endfunction

    // leave not-ready on its own, then the table transition (same guard)
    assign w_mode1  = (r_mode == ST_NOTREADY && i_item.guard_ok) ? ST_DISABLED : r_mode;
    assign w_pwm1   = (r_mode == ST_NOTREADY && i_item.guard_ok) ? 1'b0 : r_pwm;
    assign w_target = cw_target(w_mode1, i_item.control_word, r_last);

    always_comb begin
        n_mode   = r_mode;
        n_pwm    = r_pwm;
        n_status = r_status;
        n_last   = r_last;
        if (i_item.cmd == CMD_FAULT) begin
            if (r_mode != ST_FAULT && i_item.guard_ok) begin
                n_mode   = ST_FAULT;
                n_pwm    = 1'b0;
                n_status = status_of(ST_FAULT);
            end
        end else begin
            n_mode = w_mode1;
            n_pwm  = w_pwm1;
            if (i_item.guard_ok && w_target != w_mode1) begin
                n_mode = w_target;
                n_pwm  = pwm_after(w_target, w_pwm1);
            end
            n_status = status_of(n_mode);
            n_last   = i_item.control_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ST_NOTREADY;
            r_last   <= '0;
            r_status <= SW_RESET_VALUE;
            r_pwm    <= 1'b0;
        end else if (i_commit) begin
            r_mode   <= n_mode;
            r_last   <= n_last;
            r_status <= n_status;
            r_pwm    <= n_pwm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_result.drive_state   <= n_mode;
            r_result.status_word   <= n_status;
            r_result.pwm_on        <= n_pwm;
            r_result.state_changed <= (n_mode != r_mode);
        end
    end

    assign o_result = r_result;

    // power stage is never on while disabled, not ready or in fault
    `ASSERT_CLK_RST(a_pwm_off_states, i_clk, i_rst_n, r_pwm |-> (r_mode != ST_DISABLED && r_mode != ST_FAULT && r_mode != ST_NOTREADY), "pwm on in a power-off state")
    // a denied request leaves state and power stage alone
    `ASSERT_CLK_RST(a_guard_hold, i_clk, i_rst_n, (i_commit && !i_item.guard_ok) |=> ($stable(r_mode) && $stable(r_pwm)), "state changed with guard denied")
    // every committed update request leaves the voltage-enabled bit set
    `ASSERT_CLK_RST(a_voltage_bit, i_clk, i_rst_n, (i_commit && i_item.cmd == CMD_UPDATE) |=> r_status[4], "voltage bit clear after update")
    // a fault request never moves the block out of fault
    `ASSERT_CLK_RST(a_fault_sticky, i_clk, i_rst_n, (i_commit && r_mode == ST_FAULT && i_item.cmd == CMD_FAULT) |=> r_mode == ST_FAULT, "left fault on fault request")

endmodule

[dv/dsm_result_checker.sv]
// Result checker for the drive power state machine: predicts each result from
// the accepted requests and compares it with what the block hands out.
// Depends on dsm_pkg for the result struct and the controlword patterns.
`timescale 1ns / 100ps

module dsm_result_checker import dsm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel, as seen at the block's ports
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  logic        i_cmd,
    input  logic [15:0] i_control_word,
    input  logic        i_guard_ok,
    // result channel
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [3:0]  i_drive_state,
    input  logic [15:0] i_status_word,
    input  logic        i_pwm_on,
    input  logic        i_state_changed,
    output int          o_pending,
    output int          o_fail_count
);

    typedef enum logic [3:0] {
        DS_NOT_READY          = 4'd0,
        DS_SWITCH_ON_DISABLED = 4'd1,
        DS_READY              = 4'd2,
        DS_SWITCHED_ON        = 4'd3,
        DS_OP_ENABLED         = 4'd4,
        DS_QUICK_STOP         = 4'd5,
        DS_FAULT_REACTION     = 4'd6,
        DS_FAULT              = 4'd7,
        DS_CALIBRATING        = 4'd8
    } t_drive_state;

    logic [3:0]  drive_mode;
    logic [15:0] prev_control;
    logic [15:0] statusword_q;
    logic        power_stage_on;
    t_result     expected_results[$];
    int          fails = 0;

    assign o_fail_count = fails;

    function automatic logic [15:0] statusword_of(input logic [3:0] mode);
        logic [15:0] pat;
        case (mode)
            DS_SWITCH_ON_DISABLED: pat = 16'h0040;
            DS_READY:              pat = 16'h0021;
            DS_SWITCHED_ON:        pat = 16'h0023;
            DS_OP_ENABLED:         pat = 16'h0027;
            DS_QUICK_STOP:         pat = 16'h0007;
            DS_FAULT_REACTION:     pat = 16'h000F;
            DS_FAULT:              pat = 16'h0008;
            DS_CALIBRATING:        pat = 16'h0100;
            default:               pat = 16'h0000;
        endcase
        return pat | SW_VOLTAGE;
    endfunction

    // Target of the first matching controlword rule; the current state when none matches.
    function automatic logic [3:0] commanded_state(input logic [3:0] mode,
                                                   input logic [15:0] cw,
                                                   input logic [15:0] prev);
        logic shutdown, switch_on, voltage_off, enable_op, disable_op, quick_stop, calibrate;
        shutdown    = (cw & CW_MASK_CMD) == CW_SHUTDOWN;
        switch_on   = (cw & CW_MASK_CMD) == CW_SWITCH_ON;
        voltage_off = (cw & CW_EN_VOLTAGE) == 16'h0000;
        enable_op   = (cw & CW_MASK_OP) == CW_ENABLE_OP;
        disable_op  = (cw & CW_MASK_OP) == CW_DISABLE_OP;
        quick_stop  = (cw & CW_QUICK_STOP) == 16'h0000;
        calibrate   = (cw & CW_CALIBRATE) == CW_CALIBRATE;
        case (mode)
            DS_NOT_READY: return DS_SWITCH_ON_DISABLED;
            DS_SWITCH_ON_DISABLED: begin
                if (shutdown) return DS_READY;
            end
            DS_READY: begin
                if (switch_on)   return DS_SWITCHED_ON;
                if (voltage_off) return DS_SWITCH_ON_DISABLED;
                if (calibrate)   return DS_CALIBRATING;
            end
            DS_SWITCHED_ON: begin
                if (shutdown)    return DS_READY;
                if (voltage_off) return DS_SWITCH_ON_DISABLED;
                if (enable_op)   return DS_OP_ENABLED;
            end
            DS_OP_ENABLED: begin
                if (shutdown)    return DS_READY;
                if (voltage_off) return DS_SWITCH_ON_DISABLED;
                if (disable_op)  return DS_SWITCHED_ON;
                if (quick_stop)  return DS_QUICK_STOP;
            end
            DS_QUICK_STOP: begin
                if (voltage_off) return DS_SWITCH_ON_DISABLED;
                if (enable_op)   return DS_OP_ENABLED;
            end
            DS_CALIBRATING: begin
                if (voltage_off) return DS_SWITCH_ON_DISABLED;
            end
            DS_FAULT_REACTION: return DS_FAULT;
            DS_FAULT: begin
                // fault reset only on a rising edge of its bit
                if ((cw & CW_FAULT_RESET) != 0 && (prev & CW_FAULT_RESET) == 0)
                    return DS_SWITCH_ON_DISABLED;
            end
            default: ;
        endcase
        return mode;
    endfunction

    function automatic void enter_state(input logic [3:0] target, input logic guard);
        if (target == drive_mode || !guard)
            return;
        drive_mode = target;
        if (target == DS_OP_ENABLED)
            power_stage_on = 1'b1;
        else if (target == DS_SWITCH_ON_DISABLED || target == DS_FAULT)
            power_stage_on = 1'b0;
        statusword_q = statusword_of(target);
    endfunction

    function automatic t_result advance_drive(input logic cmd, input logic [15:0] cw,
                                              input logic guard);
        logic [3:0] start_mode;
        t_result    res;
        start_mode = drive_mode;
        if (cmd == CMD_FAULT) begin
            enter_state(DS_FAULT, guard);
        end else begin
            if (drive_mode == DS_NOT_READY)
                enter_state(DS_SWITCH_ON_DISABLED, guard);
            enter_state(commanded_state(drive_mode, cw, prev_control), guard);
            prev_control = cw;
            statusword_q = statusword_of(drive_mode);
        end
        res.drive_state   = drive_mode;
        res.status_word   = statusword_q;
        res.pwm_on        = power_stage_on;
        res.state_changed = drive_mode != start_mode;
        return res;
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] exp_val,
                                          input logic [15:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s: expected 0x%04h, got 0x%04h", name, exp_val, got_val);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            drive_mode     = DS_NOT_READY;
            prev_control   = 16'h0000;
            statusword_q   = SW_RESET_VALUE;
            power_stage_on = 1'b0;
            expected_results.delete();
        end else begin
            // request first, so a same-edge result would still find its expectation
            if (i_req_valid && !i_req_stall)
                expected_results.push_back(advance_drive(i_cmd, i_control_word, i_guard_ok));
            if (i_res_valid && !i_res_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: state %0d status 0x%04h",
                           i_drive_state, i_status_word);
                    fails++;
                end else begin
                    exp_res = expected_results.pop_front();
                    compare_field("drive_state", 16'(exp_res.drive_state),
                                  16'(i_drive_state));
                    compare_field("status_word", exp_res.status_word, i_status_word);
                    compare_field("pwm_on", 16'(exp_res.pwm_on), 16'(i_pwm_on));
                    compare_field("state_changed", 16'(exp_res.state_changed),
                                  16'(i_state_changed));
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

[dv/tb_drive_power_state_machine.sv]
// Testbench top for the drive power state machine: drives directed and random
// requests with bursty valid and patterned result stall, and reports the verdict.
// Depends on dsm_pkg, the block itself and dsm_result_checker.
`timescale 1ns / 100ps

module tb_drive_power_state_machine;
    import dsm_pkg::*;

    // Shapes of controlword that a random request takes; the bits outside each
    // shape's mask stay random so the don't-care bits get exercised too.
    typedef enum int {
        CWK_SHUTDOWN,
        CWK_SWITCH_ON,
        CWK_ENABLE_OP,
        CWK_DISABLE_OP,
        CWK_VOLTAGE_OFF,
        CWK_QUICK_STOP,
        CWK_CALIBRATE,
        CWK_FAULT_RESET
    } t_cw_kind;

    localparam int RANDOM_REQUESTS = 950;
    localparam int DRAIN_CYCLES    = 8;    // slack after the last result drains

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic        req_cmd   = CMD_UPDATE;
    logic [15:0] req_cw    = 16'h0000;
    logic        req_guard = 1'b0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [3:0]  res_state;
    logic [15:0] res_status;
    logic        res_pwm;
    logic        res_changed;

    int          pending;
    int          fail_count;
    t_item       request_plan[$];

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    drive_power_state_machine dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (req_valid),
        .o_stall         (req_stall),
        .i_cmd           (req_cmd),
        .i_control_word  (req_cw),
        .i_guard_ok      (req_guard),
        .o_valid         (res_valid),
        .i_stall         (res_stall),
        .o_drive_state   (res_state),
        .o_status_word   (res_status),
        .o_pwm_on        (res_pwm),
        .o_state_changed (res_changed)
    );

    dsm_result_checker checker_inst (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (req_valid),
        .i_req_stall     (req_stall),
        .i_cmd           (req_cmd),
        .i_control_word  (req_cw),
        .i_guard_ok      (req_guard),
        .i_res_valid     (res_valid),
        .i_res_stall     (res_stall),
        .i_drive_state   (res_state),
        .i_status_word   (res_status),
        .i_pwm_on        (res_pwm),
        .i_state_changed (res_changed),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    // Result-side stall: picks a pattern for a random stretch of cycles. Patterns
    // are never stalled, light random, heavy random, and long stall runs.
    int stall_pattern = 0;
    int stall_left    = 0;
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_pattern <= $urandom_range(0, 3);
            stall_left    <= $urandom_range(8, 60);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_pattern)
            0:       res_stall <= 1'b0;
            1:       res_stall <= ($urandom_range(0, 3) == 0);
            2:       res_stall <= ($urandom_range(0, 1) == 0);
            default: res_stall <= (stall_left % 8) >= 3;   // periodic runs of stalled cycles
        endcase
    end

    function automatic void queue_request(input logic cmd, input logic [15:0] cw,
                                          input logic guard);
        t_item it;
        it.cmd          = cmd;
        it.control_word = cw;
        it.guard_ok     = guard;
        request_plan.push_back(it);
    endfunction

    // Random controlword that still decodes as the chosen command.
    function automatic logic [15:0] shaped_controlword(input t_cw_kind kind);
        logic [15:0] mask, value, noise;
        noise = 16'($urandom());
        case (kind)
            CWK_SHUTDOWN:    begin mask = CW_MASK_CMD;    value = CW_SHUTDOWN;   end
            CWK_SWITCH_ON:   begin mask = CW_MASK_CMD;    value = CW_SWITCH_ON;  end
            CWK_ENABLE_OP:   begin mask = CW_MASK_OP;     value = CW_ENABLE_OP;  end
            CWK_DISABLE_OP:  begin mask = CW_MASK_OP;     value = CW_DISABLE_OP; end
            CWK_VOLTAGE_OFF: begin mask = CW_EN_VOLTAGE;  value = 16'h0000;      end
            // voltage kept on, quick stop bit low
            CWK_QUICK_STOP: begin
                mask  = CW_EN_VOLTAGE | CW_QUICK_STOP;
                value = CW_EN_VOLTAGE;
            end
            // calibrate bit set, voltage on, bit 0 low so it is not a switch-on
            CWK_CALIBRATE: begin
                mask  = CW_CALIBRATE | CW_SWITCH_ON;
                value = CW_CALIBRATE | CW_EN_VOLTAGE;
            end
            default:         begin mask = CW_FAULT_RESET; value = CW_FAULT_RESET; end
        endcase
        return (noise & ~mask) | value;
    endfunction

    initial begin
        int roll;
        int idx;
        int burst;
        int gap;

        // Directed walk through the state graph.
        queue_request(CMD_UPDATE, 16'h0000, 1'b0);  // leaving not-ready refused by guard
        queue_request(CMD_UPDATE, 16'h0000, 1'b1);  // not-ready -> switch-on disabled
        queue_request(CMD_UPDATE, 16'hFFFF, 1'b1);  // all ones: no rule matches
        queue_request(CMD_UPDATE, 16'h0006, 1'b0);  // shutdown refused by guard
        queue_request(CMD_UPDATE, 16'h0006, 1'b1);  // -> ready
        queue_request(CMD_UPDATE, 16'h0102, 1'b1);  // -> calibrating
        queue_request(CMD_UPDATE, 16'h0000, 1'b1);  // -> switch-on disabled
        queue_request(CMD_UPDATE, 16'h0006, 1'b1);  // -> ready
        queue_request(CMD_UPDATE, 16'h0007, 1'b1);  // -> switched on
        queue_request(CMD_UPDATE, 16'h000F, 1'b1);  // -> enabled, PWM on
        queue_request(CMD_UPDATE, 16'h0007, 1'b1);  // disable operation
        queue_request(CMD_UPDATE, 16'h000F, 1'b1);  // enable again
        queue_request(CMD_UPDATE, 16'h0002, 1'b1);  // -> quick stop
        queue_request(CMD_UPDATE, 16'h000F, 1'b1);  // quick stop -> enabled
        queue_request(CMD_FAULT,  16'hFFFF, 1'b0);  // fault entry refused
        queue_request(CMD_FAULT,  16'hFFFF, 1'b1);  // -> fault, PWM off
        queue_request(CMD_FAULT,  16'h0000, 1'b1);  // fault entry while in fault
        queue_request(CMD_UPDATE, 16'h0000, 1'b1);  // fault holds, bit 7 low recorded
        queue_request(CMD_UPDATE, 16'h0080, 1'b0);  // rising edge refused by guard
        queue_request(CMD_UPDATE, 16'h00FF, 1'b1);  // bit 7 already high: no edge
        queue_request(CMD_UPDATE, 16'h0000, 1'b1);
        queue_request(CMD_UPDATE, 16'h0080, 1'b1);  // fault reset -> switch-on disabled
        queue_request(CMD_UPDATE, 16'h0006, 1'b1);
        queue_request(CMD_UPDATE, 16'h0007, 1'b1);
        queue_request(CMD_UPDATE, 16'h000F, 1'b1);
        queue_request(CMD_UPDATE, 16'h0006, 1'b1);  // enabled -> ready keeps PWM set
        queue_request(CMD_UPDATE, 16'hFFFD, 1'b1);  // ready, voltage off -> disabled

        // Random part: mostly well-formed commands, with some fault entries,
        // raw controlwords and refused transitions mixed in.
        repeat (RANDOM_REQUESTS) begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                queue_request(CMD_FAULT, 16'($urandom()), $urandom_range(0, 9) != 0);
            else if (roll < 15)
                queue_request(CMD_UPDATE, 16'($urandom()), $urandom_range(0, 9) != 0);
            else
                queue_request(CMD_UPDATE,
                              shaped_controlword(t_cw_kind'($urandom_range(0, 7))),
                              $urandom_range(0, 9) != 0);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Bursts of back-to-back requests, separated by idle gaps (sometimes none).
        idx = 0;
        while (idx < request_plan.size()) begin
            burst = $urandom_range(1, 24);
            for (int n = 0; n < burst && idx < request_plan.size(); n++) begin
                req_valid <= 1'b1;
                req_cmd   <= request_plan[idx].cmd;
                req_cw    <= request_plan[idx].control_word;
                req_guard <= request_plan[idx].guard_ok;
                @(posedge clk);
                while (req_stall) @(posedge clk);
                idx++;
            end
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_valid <= 1'b0;

        // Let the last request reach the checker, then drain the results.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
